>>> hw/rtl/bbcw_pkg.sv
// ----------------------------------------------------------------------------
// bbcw_pkg
// shared types and fixed constants of the clipped-window box blur
// ----------------------------------------------------------------------------
`default_nettype none

package bbcw_pkg;

  localparam int CH_W   = 8;   // one color channel of an input pixel
  localparam int MEAN_W = 16;  // scaled mean of one channel
  localparam int POS_W  = 11;  // output row and column fields
  localparam int WIN_W  = 4;   // window size register
  localparam int DIM_W  = 12;  // image width and height registers
  localparam int IDX_W  = 2;   // configuration register index
  localparam int NUM_CH = 3;
  localparam int PIX_W  = NUM_CH * CH_W;

  localparam int HEIGHT_LIMIT = 2048;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WIN_W-1:0] RESET_WINDOW_SIZE  = 4'd3;
  localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RADDR,
    S_RACC,
    S_RING,
    S_JSET,
    S_WIN,
    S_DSTART,
    S_DWAIT,
    S_PUSH,
    S_WRITE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/box_blur_clipped_window.sv
// ----------------------------------------------------------------------------
// box_blur_clipped_window
// three-channel mean blur over a square window, clipped at the row ends
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel, and the block is
// busy (in_stall high) until the last result that pixel causes has been
// loaded into the result register. An odd window size k from 3 up to
// MAX_WINDOW gives the window mean of each channel as round(sum*257/count),
// where the window is clipped left and right at the image edges and count
// is the number of cells inside it. Only rows whose full window fits
// vertically produce output, and each row's last pixel flushes the
// remaining columns, so one pixel gives up to (k+1)/2 results, the last one
// flagged by run_end. Even sizes and sizes below three or above MAX_WINDOW
// pass each pixel through scaled by 257. A pixel in an output row is
// accepted, then takes one read and one add per stored row from the line
// store, the ring write and the line store write. Each result adds a setup
// step, one add per column of the clipped window over the column-sum ring,
// three passes of the shared 16-step divider and the load of the result
// register, which waits while the result side stalls. Pass-through accepts,
// loads the result and writes the line store; rows above the first full
// window only accept and write. A write to any of the three registers
// restarts the image at row zero, column zero. The line store needs no
// clearing after reset, only rows already written in the current image are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_clipped_window import bbcw_pkg::*; #(
  parameter int MAX_WINDOW      = 15,
  parameter int MAX_IMAGE_WIDTH = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write channel
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data,
  // pixel input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [CH_W-1:0]   chan_zero_in,
  input  wire logic [CH_W-1:0]   chan_one_in,
  input  wire logic [CH_W-1:0]   chan_two_in,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [MEAN_W-1:0] chan_zero_mean,
  output      logic [MEAN_W-1:0] chan_one_mean,
  output      logic [MEAN_W-1:0] chan_two_mean,
  output      logic [POS_W-1:0]  out_row,
  output      logic [POS_W-1:0]  out_column,
  output      logic              run_end
);

  // derived sizes
  localparam int CW         = $clog2(MAX_IMAGE_WIDTH);
  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int RW         = $clog2(MAX_WINDOW);
  localparam int CSW        = $clog2(255 * MAX_WINDOW + 1);
  localparam int WSW        = $clog2(255 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int CNW        = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int NW         = $clog2(514 * 255 * MAX_WINDOW * MAX_WINDOW
                                     + MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DW         = CNW + 1;
  localparam int AW         = SW + CW;
  localparam int DEPTH      = STORE_ROWS * (1 << CW);

  // configuration registers
  logic [WIN_W-1:0] win_size;
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  // image position and ring pointers
  logic [POS_W-1:0] row_pos;
  logic [CW-1:0]    col_pos;
  logic [SW-1:0]    row_slot;
  logic [RW-1:0]    ring_ptr;

  state_t state, state_next;

  // per-pixel working registers
  logic [PIX_W-1:0]   px;
  logic               pass_mode;
  logic [WIN_W-1:0]   rd_cnt;
  logic [SW-1:0]      rd_slot;
  logic [CSW-1:0]     col_acc [NUM_CH];
  logic [NUM_CH*CSW-1:0] ring [MAX_WINDOW];
  logic [CW-1:0]      j;
  logic [CW-1:0]      j_last;
  logic [RW-1:0]      mcnt;
  logic [RW-1:0]      rp;
  logic [CNW-1:0]     count_r;
  logic [WSW-1:0]     win_acc [NUM_CH];
  logic [1:0]         ch_sel;
  logic [MEAN_W-1:0]  mean_r [NUM_CH];

  // effective image size
  logic [CW:0]        eff_w;
  logic [CW-1:0]      col_last;
  logic [DIM_W-1:0]   eff_h;
  logic [WIN_W-1:0]   half_w;
  logic [CW-1:0]      half_c;
  logic               pass_now;
  logic               row_ready;

  // ram
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [PIX_W-1:0]   ram_rdata;

  // divider
  logic               div_start;
  logic               div_done;
  logic [MEAN_W-1:0]  div_quot;
  logic [NW-1:0]      div_num;
  logic [WSW-1:0]     div_sum;

  // window bounds for the current output column
  logic [CW-1:0]      lo_c;
  logic [CW:0]        jh_c;
  logic [CW-1:0]      hi_c;
  logic [CW-1:0]      span_c;
  logic [CW-1:0]      diff_c;
  logic [RW:0]        rp_wrap;

  // control from the sequencer
  logic               take_in;
  logic               load_out;
  logic               out_free;
  logic               cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_WINDOW_SIZE ||
                                   cfg_index == REG_IMAGE_WIDTH ||
                                   cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    if (img_w == '0) begin
      eff_w = (CW+1)'(1);
    end else if (int'(img_w) > MAX_IMAGE_WIDTH) begin
      eff_w = (CW+1)'(MAX_IMAGE_WIDTH);
    end else begin
      eff_w = (CW+1)'(img_w);
    end
    if (img_h == '0) begin
      eff_h = DIM_W'(1);
    end else if (int'(img_h) > HEIGHT_LIMIT) begin
      eff_h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = img_h;
    end
  end

  assign col_last  = CW'(eff_w - 1'b1);
  assign half_w    = (win_size - 1'b1) >> 1;
  assign half_c    = CW'(half_w);
  assign pass_now  = !win_size[0] || (win_size < WIN_W'(3)) ||
                     (int'(win_size) > MAX_WINDOW);
  assign row_ready = (int'(row_pos) >= int'(win_size) - 1);

  // clipped window around output column j
  assign lo_c    = (j >= half_c) ? j - half_c : '0;
  assign jh_c    = {1'b0, j} + (CW+1)'(half_c);
  assign hi_c    = (jh_c < {1'b0, col_last}) ? CW'(jh_c) : col_last;
  assign span_c  = hi_c - lo_c;
  assign diff_c  = col_pos - lo_c;
  assign rp_wrap = (RW+1)'(ring_ptr) + (RW+1)'(MAX_WINDOW) - (RW+1)'(diff_c);

  assign ram_raddr = {rd_slot, col_pos};
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (ch_sel)
      2'd0:    div_sum = win_acc[0];
      2'd1:    div_sum = win_acc[1];
      default: div_sum = win_acc[2];
    endcase
  end

  // sum*514 + count, so that the quotient by 2*count rounds half up
  assign div_num = NW'({div_sum, 9'b0}) + NW'({div_sum, 1'b0}) + NW'(count_r);

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    take_in    = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          take_in = 1'b1;
          if (pass_now) begin
            state_next = S_PUSH;
          end else if (row_ready) begin
            state_next = S_RADDR;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_RADDR: begin
        ram_re     = 1'b1;
        state_next = S_RACC;
      end
      S_RACC: begin
        state_next = (rd_cnt == win_size - 1'b1) ? S_RING : S_RADDR;
      end
      S_RING: begin
        state_next = (col_pos >= half_c || col_pos == col_last) ? S_JSET : S_WRITE;
      end
      S_JSET: begin
        state_next = S_WIN;
      end
      S_WIN: begin
        state_next = (mcnt == '0) ? S_DSTART : S_WIN;
      end
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_next = (ch_sel == 2'd2) ? S_PUSH : S_DSTART;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pass_mode || j == j_last) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_JSET;
          end
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration and image position
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= RESET_WINDOW_SIZE;
      img_w    <= RESET_IMAGE_WIDTH;
      img_h    <= RESET_IMAGE_HEIGHT;
      row_pos  <= '0;
      col_pos  <= '0;
      row_slot <= '0;
      ring_ptr <= '0;
    end else begin
      if (ram_we) begin
        // step to the next pixel, wrapping rows and the frame
        if ({1'b0, col_pos} + 1'b1 >= eff_w) begin
          col_pos  <= '0;
          ring_ptr <= '0;
          if (DIM_W'(row_pos) + 1'b1 >= eff_h) begin
            row_pos  <= '0;
            row_slot <= '0;
          end else begin
            row_pos  <= row_pos + 1'b1;
            row_slot <= (row_slot == SW'(STORE_ROWS - 1)) ? '0 : row_slot + 1'b1;
          end
        end else begin
          col_pos  <= col_pos + 1'b1;
          ring_ptr <= (ring_ptr == RW'(MAX_WINDOW - 1)) ? '0 : ring_ptr + 1'b1;
        end
      end
      if (cfg_hit) begin
        case (cfg_index)
          REG_WINDOW_SIZE: win_size <= cfg_data[WIN_W-1:0];
          REG_IMAGE_WIDTH: img_w    <= cfg_data;
          default:         img_h    <= cfg_data;
        endcase
        // any register write starts a new image
        row_pos  <= '0;
        col_pos  <= '0;
        row_slot <= '0;
        ring_ptr <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      px        <= {chan_two_in, chan_one_in, chan_zero_in};
      pass_mode <= pass_now;
      rd_cnt    <= WIN_W'(1);
      rd_slot   <= (row_slot == '0) ? SW'(STORE_ROWS - 1) : row_slot - 1'b1;
      col_acc[0] <= CSW'(chan_zero_in);
      col_acc[1] <= CSW'(chan_one_in);
      col_acc[2] <= CSW'(chan_two_in);
    end
    if (state == S_RACC) begin
      // add one stored row to the column sum
      for (int c = 0; c < NUM_CH; c++) begin
        col_acc[c] <= col_acc[c] + CSW'(ram_rdata[c*CH_W +: CH_W]);
      end
      rd_cnt  <= rd_cnt + 1'b1;
      rd_slot <= (rd_slot == '0) ? SW'(STORE_ROWS - 1) : rd_slot - 1'b1;
    end
    if (state == S_RING) begin
      ring[ring_ptr] <= {col_acc[2], col_acc[1], col_acc[0]};
      j      <= (col_pos >= half_c) ? col_pos - half_c : '0;
      j_last <= (col_pos == col_last) ? col_last
                : ((col_pos >= half_c) ? col_pos - half_c : '0);
    end
    if (state == S_JSET) begin
      mcnt    <= RW'(span_c);
      count_r <= CNW'(CNW'(span_c) + 1'b1) * CNW'(win_size);
      rp      <= (ring_ptr >= RW'(diff_c)) ? ring_ptr - RW'(diff_c) : RW'(rp_wrap);
      for (int c = 0; c < NUM_CH; c++) begin
        win_acc[c] <= '0;
      end
    end
    if (state == S_WIN) begin
      // one stored column sum per cycle from the ring
      for (int c = 0; c < NUM_CH; c++) begin
        win_acc[c] <= win_acc[c] + WSW'(ring[rp][c*CSW +: CSW]);
      end
      rp     <= (rp == RW'(MAX_WINDOW - 1)) ? '0 : rp + 1'b1;
      mcnt   <= mcnt - 1'b1;
      ch_sel <= 2'd0;
    end
    if (state == S_DWAIT && div_done) begin
      case (ch_sel)
        2'd0:    mean_r[0] <= div_quot;
        2'd1:    mean_r[1] <= div_quot;
        default: mean_r[2] <= div_quot;
      endcase
      ch_sel <= ch_sel + 1'b1;
    end
    if (load_out && !pass_mode) begin
      j <= j + 1'b1;
    end
  end

  // result register, separate from the sequencer so a held result
  // does not block the next computation step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (pass_mode) begin
        chan_zero_mean <= {px[7:0], px[7:0]};
        chan_one_mean  <= {px[15:8], px[15:8]};
        chan_two_mean  <= {px[23:16], px[23:16]};
        out_row        <= row_pos;
        out_column     <= POS_W'(col_pos);
        run_end        <= 1'b1;
      end else begin
        chan_zero_mean <= mean_r[0];
        chan_one_mean  <= mean_r[1];
        chan_two_mean  <= mean_r[2];
        out_row        <= row_pos - POS_W'(win_size) + 1'b1;
        out_column     <= POS_W'(j);
        run_end        <= (j == j_last);
      end
    end
  end

  bbcw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({row_slot, col_pos}),
    .wdata (px),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbcw_div #(
    .NW (NW),
    .DW (DW),
    .QW (MEAN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({count_r, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bbcw_ram.sv
// ----------------------------------------------------------------------------
// bbcw_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bbcw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 28672
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bbcw_div.sv
// ----------------------------------------------------------------------------
// bbcw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bbcw_div #(
  parameter int NW = 25,  // numerator width
  parameter int DW = 9,   // divisor width
  parameter int QW = 16   // quotient width, numerator >> QW must be below divisor
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output      logic          done,
  output      logic [QW-1:0] quot
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [QW-1:0]    nq;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DW:0]      cand;
  logic             take;

  assign cand = {rem, nq[QW-1]};
  assign take = (cand >= {1'b0, den_r});
  assign quot = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNT_W'(QW);
        rem   <= DW'(num >> QW);
        nq    <= num[QW-1:0];
        den_r <= den;
      end else if (run) begin
        // shift in next numerator bit, subtract when it fits
        rem <= take ? DW'(cand - {1'b0, den_r}) : cand[DW-1:0];
        nq  <= {nq[QW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/box_blur_clipped_window_tb.sv
// ----------------------------------------------------------------------------
// box_blur_clipped_window_tb
// self-checking bench for the clipped-window three-channel box blur
// ----------------------------------------------------------------------------
// A behavioral blur model is run on every accepted pixel. Its results are
// queued and compared field by field with each result transaction. Directed
// tests cover pass-through, register extremes and a small full blur. Random
// images with random window sizes follow. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_clipped_window_tb import bbcw_pkg::*; ();

  localparam int STORE_ROWS   = 14;
  localparam int RING_DEPTH   = 15;
  localparam int MAX_WIDTH    = 2048;
  localparam int WATCHDOG_MAX = 40000;
  localparam int SETTLE_CYC   = 300;
  localparam int ITEM_TARGET  = 420;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // not a register, ignored

  typedef struct packed {
    logic [MEAN_W-1:0] m0;
    logic [MEAN_W-1:0] m1;
    logic [MEAN_W-1:0] m2;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } blur_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [DIM_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [CH_W-1:0]   chan_zero_in;
  logic [CH_W-1:0]   chan_one_in;
  logic [CH_W-1:0]   chan_two_in;
  logic              out_valid;
  logic              out_stall;
  logic [MEAN_W-1:0] chan_zero_mean;
  logic [MEAN_W-1:0] chan_one_mean;
  logic [MEAN_W-1:0] chan_two_mean;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_column;
  logic              run_end;

  box_blur_clipped_window dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .chan_zero_in(chan_zero_in), .chan_one_in(chan_one_in),
    .chan_two_in(chan_two_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .chan_zero_mean(chan_zero_mean), .chan_one_mean(chan_one_mean),
    .chan_two_mean(chan_two_mean),
    .out_row(out_row), .out_column(out_column), .run_end(run_end)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // blur model state
  logic [PIX_W-1:0] line_mem [STORE_ROWS][MAX_WIDTH];
  logic [35:0]      col_ring [RING_DEPTH];
  int unsigned      cur_row, cur_col;
  int unsigned      win_reg, width_reg, height_reg;

  blur_result_t pending_means[$];
  int           mismatches;
  int           pixels_sent;
  bit           calm;   // no idling on either side while set

  // rounded mean scaled to 16-bit full scale
  function automatic logic [MEAN_W-1:0] scaled_mean(int unsigned sum, int unsigned cnt);
    int unsigned num;
    num = 2 * sum * 257 + cnt;
    return MEAN_W'(num / (2 * cnt));
  endfunction

  function automatic void blur_pixel(logic [CH_W-1:0] p0, logic [CH_W-1:0] p1,
                                     logic [CH_W-1:0] p2);
    int unsigned k, w, ht, r, c, hw, first, last, lo, hi, cnt;
    int unsigned csum [3];
    int unsigned sums [3];
    logic [PIX_W-1:0] v;
    logic [35:0] e;
    blur_result_t res;
    bit pass;
    k  = win_reg;
    w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    ht = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg);
    r  = cur_row;
    c  = cur_col;
    pass = (k[0] == 1'b0) || k < 3 || k > RING_DEPTH;
    if (pass) begin
      res.m0 = p0 * 257; res.m1 = p1 * 257; res.m2 = p2 * 257;
      res.row = POS_W'(r); res.col = POS_W'(c); res.last = 1'b1;
      pending_means = {pending_means, res};
    end else if (r >= k - 1) begin
      hw = (k - 1) / 2;
      csum[0] = p0; csum[1] = p1; csum[2] = p2;
      for (int unsigned d = 1; d < k; d++) begin
        v = line_mem[(r - d) % STORE_ROWS][c];
        for (int ch = 0; ch < 3; ch++) csum[ch] += v[8*ch +: 8];
      end
      col_ring[c % RING_DEPTH] = {12'(csum[2]), 12'(csum[1]), 12'(csum[0])};
      first = (c >= hw) ? c - hw : 0;
      last  = (c == w - 1) ? w - 1 : first;
      if (c >= hw || c == w - 1) begin
        for (int unsigned j = first; j <= last; j++) begin
          lo  = (j >= hw) ? j - hw : 0;
          hi  = (j + hw < w - 1) ? j + hw : w - 1;
          cnt = (hi - lo + 1) * k;
          sums = '{0, 0, 0};
          for (int unsigned m = lo; m <= hi; m++) begin
            e = col_ring[m % RING_DEPTH];
            for (int ch = 0; ch < 3; ch++) sums[ch] += e[12*ch +: 12];
          end
          res.m0 = scaled_mean(sums[0], cnt);
          res.m1 = scaled_mean(sums[1], cnt);
          res.m2 = scaled_mean(sums[2], cnt);
          res.row = POS_W'(r - (k - 1));
          res.col = POS_W'(j);
          res.last = (j == last);
          pending_means = {pending_means, res};
        end
      end
    end
    line_mem[r % STORE_ROWS][c] = {p2, p1, p0};
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= ht) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      REG_WINDOW_SIZE:  win_reg    = val[WIN_W-1:0];
      REG_IMAGE_WIDTH:  width_reg  = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default: return;
    endcase
    cur_row = 0;
    cur_col = 0;
  endfunction

  // one pixel transaction, with a random gap ahead of it
  task automatic send_pixel(logic [CH_W-1:0] p0, logic [CH_W-1:0] p1, logic [CH_W-1:0] p2);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    chan_zero_in <= p0;
    chan_one_in  <= p1;
    chan_two_in  <= p2;
    do @(posedge clk); while (in_stall);
    blur_pixel(p0, p1, p2);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait until the block has drained everything it owes
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_image(int unsigned k, int unsigned w, int unsigned ht);
    wait_drained();
    // upper data bits on the window register are don't-care
    write_register(REG_WINDOW_SIZE, {8'($urandom), 4'(k)});
    write_register(REG_IMAGE_WIDTH, DIM_W'(w));
    write_register(REG_IMAGE_HEIGHT, DIM_W'(ht));
  endtask

  // even, small and zero window sizes, channel extremes
  task automatic test_pass_through();
    set_image(4, 3, 2);
    send_pixel(8'h00, 8'hff, 8'h55);
    send_pixel(8'hff, 8'h00, 8'haa);
    send_pixel(8'haa, 8'h55, 8'hff);
    set_image(0, 0, 0);   // zero width and height act as one
    send_pixel(8'h01, 8'h80, 8'hfe);
    send_pixel(8'h7f, 8'hfe, 8'h01);
    set_image(2, 4095, 4095);   // saturated width and height
    send_pixel(8'hff, 8'hff, 8'hff);
    set_image(1, 2, 1);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_random_pixel();
  endtask

  // index three is not a register, so the image position must carry on
  task automatic test_spare_index();
    set_image(14, 2, 2);
    send_random_pixel();
    wait_drained();
    write_register(REG_SPARE, 12'hfff);
    send_random_pixel();
  endtask

  // full 3x3 window on a tiny image, extreme values and clipping at both ends
  task automatic test_small_blur();
    set_image(3, 3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) send_pixel(8'hff, 8'hff, 8'h00);
      else send_pixel(8'h00, 8'hff, 8'hff);
    end
  endtask

  // window taller than the image gives nothing
  task automatic test_window_too_tall();
    set_image(5, 1, 3);
    for (int i = 0; i < 3; i++) send_random_pixel();
  endtask

  // random images, mostly small windows and narrow rows
  task automatic test_random_images();
    int unsigned k, w, ht, n, pick;
    bit first_phase;
    first_phase = 1'b1;
    while (pixels_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (first_phase) k = 15;
      else if (pick < 6) k = 2 * $urandom_range(1, 3) + 1;
      else if (pick < 8) k = 2 * $urandom_range(4, 7) + 1;
      else k = $urandom_range(0, 7) * 2 + ($urandom_range(0, 1) ? 0 : 1) % 2 * 0;
      w  = first_phase ? 1 : ($urandom_range(0, 7) == 0 ? $urandom_range(11, 20)
                                                       : $urandom_range(1, 10));
      ht = k + $urandom_range(0, 2);
      if (k < 3 || k[0] == 1'b0) ht = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0 && k > 1) ht = k - 1;
      n = w * ht + ($urandom_range(0, 3) == 0 ? w + $urandom_range(0, w) : 0);
      // keep the total pixel count near the target
      if (n > ITEM_TARGET - pixels_sent) n = ITEM_TARGET - pixels_sent;
      calm = ($urandom_range(0, 3) == 0);
      set_image(k, w, ht);
      for (int unsigned i = 0; i < n; i++) send_random_pixel();
      calm = 1'b0;
      first_phase = 1'b0;
    end
  endtask

  // result checking
  always @(posedge clk) begin
    blur_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{chan_zero_mean, chan_one_mean, chan_two_mean, out_row, out_column, run_end};
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_means.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // result side stall pattern
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    chan_zero_in = '0;
    chan_one_in = '0;
    chan_two_in = '0;
    mismatches = 0;
    pixels_sent = 0;
    calm = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) col_ring[i] = '0;
    cur_row = 0;
    cur_col = 0;
    win_reg = RESET_WINDOW_SIZE;
    width_reg = RESET_IMAGE_WIDTH;
    height_reg = RESET_IMAGE_HEIGHT;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset setting: first row only, so nothing comes out
    send_random_pixel();
    send_random_pixel();

    test_pass_through();
    test_spare_index();
    test_small_blur();
    test_window_too_tall();
    test_random_images();

    wait_drained();
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
